// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the UTF-8 sanitizer.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define UTF8S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define UTF8S_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/utf8s_pkg.sv =====
// Package of the UTF-8 sanitizer: payload structs, job descriptor, byte constants.
// Depends on nothing; used by every module of the block.
`default_nettype none
package utf8s_pkg;

  // Byte range limits of well-formed UTF-8
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Lo    = 8'hC2;
  localparam logic [7:0] Lead2Hi    = 8'hDF;
  localparam logic [7:0] Lead3Lo    = 8'hE0;
  localparam logic [7:0] Lead3Hi    = 8'hEF;
  localparam logic [7:0] Lead4Lo    = 8'hF0;
  localparam logic [7:0] Lead4Hi    = 8'hF4;
  localparam logic [7:0] ContLo     = 8'h80;
  localparam logic [7:0] ContHi     = 8'hBF;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] ContLoE0   = 8'hA0;
  localparam logic [7:0] ContHiED   = 8'h9F;
  localparam logic [7:0] ContLoF0   = 8'h90;
  localparam logic [7:0] ContHiF4   = 8'h8F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } utf8s_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } utf8s_out_t;

  // One classified input byte: held bytes first, then the new byte at src[held_n]
  typedef struct packed {
    logic [3:0][7:0] src;
    logic [1:0]      held_n;
    logic            held_raw;
    logic            has_b;
    logic            b_raw;
    logic            str_end;
  } utf8s_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } utf8s_qstat_t;

endpackage
`default_nettype wire

// ===== rtl/core/utf8s_front.sv =====
// Front part of the UTF-8 sanitizer: holds a partial sequence, classifies each byte
// and builds a job descriptor. Depends on utf8s_pkg.
`default_nettype none
module utf8s_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_fire_i,
  input  utf8s_pkg::utf8s_in_t  in_data_i,
  output logic                  push_o,
  output utf8s_pkg::utf8s_job_t job_o
);
  import utf8s_pkg::*;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b >= Lead2Lo && b <= Lead2Hi) n = 3'd2;
    else if (b >= Lead3Lo && b <= Lead3Hi) n = 3'd3;
    else if (b >= Lead4Lo && b <= Lead4Hi) n = 3'd4;
    return n;
  endfunction

  logic [7:0]      lead_q, lead_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [7:0]      cont_q [2];
  logic [7:0]      b;
  logic            last;
  logic [2:0]      need;
  logic [7:0]      lo, hi;
  logic            fits, complete, store_cont, fresh, hold_new, emit_held;
  logic [1:0]      held_n;
  logic [1:0]      cnt_m1;
  logic            has_b;
  logic [3:0][7:0] src;

  always_comb begin
    b    = in_data_i.in_byte;
    last = in_data_i.in_last;
    need = lead_len(lead_q);
    lo   = ContLo;
    hi   = ContHi;
    if (cnt_q == 2'd1) begin
      if (lead_q == LeadE0) lo = ContLoE0;
      else if (lead_q == LeadED) hi = ContHiED;
      else if (lead_q == LeadF0) lo = ContLoF0;
      else if (lead_q == LeadF4) hi = ContHiF4;
    end
    fits       = (need != 3'd0) && (b >= lo) && (b <= hi) && ({1'b0, cnt_q} < need);
    complete   = fits && (({1'b0, cnt_q} + 3'd1) == need);
    store_cont = (cnt_q != 2'd0) && fits && !complete && !last;
    fresh      = (cnt_q == 2'd0) || !fits;
    hold_new   = fresh && (lead_len(b) != 3'd0) && !last;
    emit_held  = (cnt_q != 2'd0) && !store_cont;
    held_n     = emit_held ? cnt_q : 2'd0;
    has_b      = !store_cont && !hold_new;
    cnt_m1     = cnt_q - 2'd1;

    src    = {8'h00, cont_q[1], cont_q[0], lead_q};
    src[held_n] = b;

    job_o.src      = src;
    job_o.held_n   = held_n;
    job_o.held_raw = complete;
    job_o.has_b    = has_b;
    job_o.b_raw    = complete || (b < AsciiLimit);
    job_o.str_end  = last;

    push_o = in_fire_i && ((held_n != 2'd0) || has_b);

    lead_d = lead_q;
    cnt_d  = cnt_q;
    if (in_fire_i) begin
      if (store_cont) begin
        cnt_d = cnt_q + 2'd1;
      end else if (hold_new) begin
        lead_d = b;
        cnt_d  = 2'd1;
      end else begin
        cnt_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      cnt_q  <= '0;
    end else begin
      lead_q <= lead_d;
      cnt_q  <= cnt_d;
    end
  end

  // Continuation store: no reset, every entry is written before it is read
  always_ff @(posedge clk_i) begin
    if (in_fire_i && store_cont) begin
      cont_q[cnt_m1[0]] <= b;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/utf8s_queue.sv =====
// Two-entry job queue between front and back of the UTF-8 sanitizer.
// Depends on utf8s_pkg.
`default_nettype none
module utf8s_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  utf8s_pkg::utf8s_job_t   push_data_i,
  input  logic                    pop_i,
  output utf8s_pkg::utf8s_job_t   pop_data_o,
  output utf8s_pkg::utf8s_qstat_t stat_o
);
  import utf8s_pkg::*;

  utf8s_job_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    stat_o.full  = (count_q == 2'd2);
    stat_o.empty = (count_q == 2'd0);
    pop_data_o   = mem_q[rd_ptr_q];
    wr_ptr_d     = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d     = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d      = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    else if (!push_i && pop_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/utf8s_back.sv =====
// Back part of the UTF-8 sanitizer: expands one job into output bytes, one per cycle
// while out_ready_i is high. Depends on utf8s_pkg.
`default_nettype none
module utf8s_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  utf8s_pkg::utf8s_job_t   job_i,
  input  utf8s_pkg::utf8s_qstat_t qstat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output utf8s_pkg::utf8s_out_t   out_data_o
);
  import utf8s_pkg::*;

  utf8s_job_t cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [1:0] idx_q, idx_d;
  logic       half_q, half_d;
  logic [7:0] sel;
  logic       raw, last_unit, last_byte, fire, load;

  always_comb begin
    sel       = cur_q.src[idx_q];
    raw       = (idx_q < cur_q.held_n) ? cur_q.held_raw : cur_q.b_raw;
    last_unit = cur_q.has_b ? (idx_q == cur_q.held_n) : (idx_q == (cur_q.held_n - 2'd1));
    last_byte = last_unit && (raw || half_q);

    out_valid_o = cur_valid_q;
    if (raw) out_data_o.out_byte = sel;
    else if (half_q) out_data_o.out_byte = {2'b10, sel[5:0]};
    else out_data_o.out_byte = {6'b110000, sel[7:6]};
    out_data_o.run_last   = last_byte;
    out_data_o.string_end = last_byte && cur_q.str_end;

    fire = cur_valid_q && out_ready_i;
    load = !cur_valid_q || (fire && last_byte);
    pop_o = load && !qstat_i.empty;

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    half_d      = half_q;
    if (load) begin
      cur_d       = job_i;
      cur_valid_d = !qstat_i.empty;
      idx_d       = 2'd0;
      half_d      = 1'b0;
    end else if (fire) begin
      // Advance to the next unit after a raw byte or a second Latin-1 byte
      if (raw || half_q) begin
        idx_d  = idx_q + 2'd1;
        half_d = 1'b0;
      end else begin
        half_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      half_q      <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      half_q      <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/utf8_sanitize_latin1_fallback.sv =====
// Top level of the UTF-8 sanitizer with Latin-1 fallback: front, job queue, back.
// Depends on utf8s_pkg, utf8s_front, utf8s_queue, utf8s_back and assert_macros.svh.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (utf8s_in_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (utf8s_out_t)
//
// The front classifies one byte per cycle and takes a transaction whenever the
// two-entry job queue has room. The back sends one output byte per cycle while
// out_ready_i is high; an input byte yields one output byte for ASCII and up to 8
// when a held sequence falls back to Latin-1, and the back keeps its job until the
// last of them is sent. Plain ASCII runs at one byte per cycle while out_ready_i
// is high. Reset clears the held count, the queue and the back; there is no
// clearing pass. A stalled output fills the queue and then drops in_ready_o.
`default_nettype none
`include "assert_macros.svh"
module utf8_sanitize_latin1_fallback (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  utf8s_pkg::utf8s_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8s_pkg::utf8s_out_t out_data_o
);
  import utf8s_pkg::*;

  logic         in_fire;
  logic         q_push;
  logic         q_pop;
  utf8s_job_t   f_job;
  utf8s_job_t   q_job;
  utf8s_qstat_t q_stat;

  // Accept a transaction whenever the queue can take a job
  assign in_ready_o = !q_stat.full;
  assign in_fire    = in_valid_i && in_ready_o;

  utf8s_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .push_o    (q_push),
    .job_o     (f_job)
  );

  utf8s_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (f_job),
    .pop_i       (q_pop),
    .pop_data_o  (q_job),
    .stat_o      (q_stat)
  );

  utf8s_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .qstat_i     (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Never push into a full queue nor pop an empty one
  `UTF8S_ASSERT(a_no_overflow, !(q_push && q_stat.full), "job queue overflow")
  `UTF8S_ASSERT(a_no_underflow, !(q_pop && q_stat.empty), "job queue underflow")
  // The final byte of a string always leaves a job behind
  `UTF8S_ASSERT(a_last_pushes, (in_fire && in_data_i.in_last) |-> q_push, "string end lost")
  // End of string only on the final byte of a run
  `UTF8S_ASSERT(a_end_on_run, (out_valid_o && out_data_o.string_end) |-> out_data_o.run_last,
                "string_end without run_last")

endmodule
`default_nettype wire
